[design/aspf_pkg.sv]
package aspf_pkg;

    // field widths
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned GROUPS_W   = 14;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 14;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // framing constants
    localparam logic [BYTE_W-1:0]   SYNC0        = 8'hAA;
    localparam logic [BYTE_W-1:0]   SYNC1        = 8'h55;
    localparam logic [CRC_W-1:0]    CRC_POLY     = 16'h1021;
    localparam logic [CRC_W-1:0]    CRC_INIT     = 16'hFFFF;
    localparam logic [GROUPS_W-1:0] GROUPS_RESET = 14'd256;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OP_MODE = 1'b0,
        CFG_GROUPS  = 1'b1
    } cfg_index_t;

    // byte positions inside the work of one item
    typedef enum logic [3:0] {
        STEP_SYNC0,
        STEP_SYNC1,
        STEP_SEQ0,
        STEP_SEQ1,
        STEP_SEQ2,
        STEP_SEQ3,
        STEP_MODE,
        STEP_LEN0,
        STEP_LEN1,
        STEP_HI,
        STEP_LOW,
        STEP_CRC0,
        STEP_CRC1
    } step_t;

    // classified item handed from front to back
    typedef struct packed {
        logic              hdr;
        logic [SEQ_W-1:0]  seq;
        logic              mode;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] hi;
        logic              grp_end;
        logic [BYTE_W-1:0] low;
        logic              pkt_end;
    } entry_t;

    // crc-16 ccitt update by one byte, msb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int j = 0; j < 8; j++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[design/aspf_sample_if.sv]
interface aspf_sample_if;
    logic                             valid;
    logic                             ready;
    logic [aspf_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[design/aspf_byte_if.sv]
interface aspf_byte_if;
    logic                           valid;
    logic                           ready;
    logic [aspf_pkg::BYTE_W-1:0]    data_byte;
    logic                           packet_end;

    modport source (output valid, output data_byte, output packet_end, input ready);
    modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

[design/aspf_front.sv]
module aspf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    aspf_sample_if.sink                         sample_ch,
    input  logic                                cfg_we,
    input  logic [aspf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aspf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                queue_full,
    output logic                                push,
    output aspf_pkg::entry_t                    push_entry
);

    logic                               op_mode_reg;
    logic [aspf_pkg::GROUPS_W-1:0]      groups_reg;
    logic [aspf_pkg::SEQ_W-1:0]         seq_reg;
    logic [aspf_pkg::SEQ_W-1:0]         seq_next;
    logic [1:0]                         phase_reg;
    logic [1:0]                         phase_next;
    logic [aspf_pkg::GROUPS_W-1:0]      group_reg;
    logic [aspf_pkg::GROUPS_W-1:0]      group_next;
    logic [5:0]                         low_reg;
    logic [5:0]                         low_next;

    logic [aspf_pkg::GROUPS_W-1:0]      eff_groups;
    logic [aspf_pkg::LEN_W-1:0]         eff_wide;
    logic                               last_group;
    logic                               accept;

    assign sample_ch.ready = !queue_full;
    assign accept          = sample_ch.valid && !queue_full;
    assign push            = accept;

    // effective group count and length field
    assign eff_groups = (groups_reg == '0) ? aspf_pkg::GROUPS_W'(1) : groups_reg;
    assign eff_wide   = aspf_pkg::LEN_W'(eff_groups);
    assign last_group = ({1'b0, group_reg} + (aspf_pkg::GROUPS_W+1)'(1)) >= {1'b0, eff_groups};

    // classify the sample
    always_comb
    begin
        push_entry.hdr     = (phase_reg == 2'd0) && (group_reg == '0);
        push_entry.seq     = seq_reg;
        push_entry.mode    = op_mode_reg;
        push_entry.len     = (eff_wide << 2) + eff_wide;
        push_entry.hi      = sample_ch.sample[aspf_pkg::SAMPLE_W-1:2];
        push_entry.grp_end = (phase_reg == 2'd3);
        push_entry.low     = {low_reg, sample_ch.sample[1:0]};
        push_entry.pkt_end = (phase_reg == 2'd3) && last_group;
    end

    // packing and packet counters
    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        group_next = group_reg;
        low_next   = low_reg;
        if (accept)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd0)
                low_next = {4'b0, sample_ch.sample[1:0]};
            else if (phase_reg != 2'd3)
                low_next = {low_reg[3:0], sample_ch.sample[1:0]};
            else
            begin
                low_next = '0;
                if (last_group)
                begin
                    group_next = '0;
                    seq_next   = seq_reg + aspf_pkg::SEQ_W'(1);
                end
                else
                    group_next = group_reg + aspf_pkg::GROUPS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= '0;
            phase_reg <= '0;
            group_reg <= '0;
            low_reg   <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            group_reg <= group_next;
            low_reg   <= low_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= 1'b0;
            groups_reg  <= aspf_pkg::GROUPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aspf_pkg::CFG_OP_MODE: op_mode_reg <= cfg_data[0];
                aspf_pkg::CFG_GROUPS:  groups_reg  <= cfg_data[aspf_pkg::GROUPS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[design/aspf_queue.sv]
module aspf_queue #(
    parameter int unsigned DEPTH = aspf_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aspf_pkg::entry_t    push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output aspf_pkg::entry_t    head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    aspf_pkg::entry_t   slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

[design/aspf_back.sv]
module aspf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  aspf_pkg::entry_t    head,
    output logic                pop,
    aspf_byte_if.source         byte_ch
);

    aspf_pkg::step_t                step_reg;
    aspf_pkg::step_t                step_next;
    aspf_pkg::step_t                cur_step;
    logic                           started_reg;
    logic                           started_next;
    logic                           item_done;
    logic [aspf_pkg::CRC_W-1:0]     crc_reg;
    logic [aspf_pkg::CRC_W-1:0]     crc_next;
    logic [aspf_pkg::BYTE_W-1:0]    cur_byte;
    logic                           cur_end;
    logic                           emit;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [aspf_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                           out_end_reg;

    assign cur_step = started_reg ? step_reg
                    : (head.hdr ? aspf_pkg::STEP_SYNC0 : aspf_pkg::STEP_HI);
    assign emit     = head_valid && (!out_valid_reg || byte_ch.ready);
    assign pop      = emit && item_done;

    // next step within the item
    always_comb
    begin
        step_next = aspf_pkg::STEP_SYNC0;
        item_done = 1'b0;
        unique case (cur_step)
            aspf_pkg::STEP_SYNC0: step_next = aspf_pkg::STEP_SYNC1;
            aspf_pkg::STEP_SYNC1: step_next = aspf_pkg::STEP_SEQ0;
            aspf_pkg::STEP_SEQ0:  step_next = aspf_pkg::STEP_SEQ1;
            aspf_pkg::STEP_SEQ1:  step_next = aspf_pkg::STEP_SEQ2;
            aspf_pkg::STEP_SEQ2:  step_next = aspf_pkg::STEP_SEQ3;
            aspf_pkg::STEP_SEQ3:  step_next = aspf_pkg::STEP_MODE;
            aspf_pkg::STEP_MODE:  step_next = aspf_pkg::STEP_LEN0;
            aspf_pkg::STEP_LEN0:  step_next = aspf_pkg::STEP_LEN1;
            aspf_pkg::STEP_LEN1:  step_next = aspf_pkg::STEP_HI;
            aspf_pkg::STEP_HI:
            begin
                if (head.grp_end)
                    step_next = aspf_pkg::STEP_LOW;
                else
                    item_done = 1'b1;
            end
            aspf_pkg::STEP_LOW:
            begin
                if (head.pkt_end)
                    step_next = aspf_pkg::STEP_CRC0;
                else
                    item_done = 1'b1;
            end
            aspf_pkg::STEP_CRC0:  step_next = aspf_pkg::STEP_CRC1;
            aspf_pkg::STEP_CRC1:  item_done = 1'b1;
            default:              item_done = 1'b1;
        endcase
    end

    // byte selected by the current step
    always_comb
    begin
        cur_end = 1'b0;
        unique case (cur_step)
            aspf_pkg::STEP_SYNC0: cur_byte = aspf_pkg::SYNC0;
            aspf_pkg::STEP_SYNC1: cur_byte = aspf_pkg::SYNC1;
            aspf_pkg::STEP_SEQ0:  cur_byte = head.seq[7:0];
            aspf_pkg::STEP_SEQ1:  cur_byte = head.seq[15:8];
            aspf_pkg::STEP_SEQ2:  cur_byte = head.seq[23:16];
            aspf_pkg::STEP_SEQ3:  cur_byte = head.seq[31:24];
            aspf_pkg::STEP_MODE:  cur_byte = {7'b0, head.mode};
            aspf_pkg::STEP_LEN0:  cur_byte = head.len[7:0];
            aspf_pkg::STEP_LEN1:  cur_byte = head.len[15:8];
            aspf_pkg::STEP_HI:    cur_byte = head.hi;
            aspf_pkg::STEP_LOW:   cur_byte = head.low;
            aspf_pkg::STEP_CRC0:  cur_byte = crc_reg[7:0];
            aspf_pkg::STEP_CRC1:
            begin
                cur_byte = crc_reg[15:8];
                cur_end  = 1'b1;
            end
            default:              cur_byte = '0;
        endcase
    end

    // running crc over payload bytes
    always_comb
    begin
        crc_next = crc_reg;
        if (emit)
        begin
            if (cur_step == aspf_pkg::STEP_SYNC0 || cur_step == aspf_pkg::STEP_CRC1)
                crc_next = aspf_pkg::CRC_INIT;
            else if (cur_step == aspf_pkg::STEP_HI || cur_step == aspf_pkg::STEP_LOW)
                crc_next = aspf_pkg::crc_byte(crc_reg, cur_byte);
        end
    end

    assign started_next   = emit ? !item_done : started_reg;
    assign out_valid_next = emit || (out_valid_reg && !byte_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= aspf_pkg::STEP_SYNC0;
            started_reg   <= 1'b0;
            crc_reg       <= aspf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                step_reg <= step_next;
            started_reg   <= started_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= cur_end;
        end
    end

    assign byte_ch.valid      = out_valid_reg;
    assign byte_ch.data_byte  = out_byte_reg;
    assign byte_ch.packet_end = out_end_reg;

endmodule

[design/adc_sample_packet_framer_top.sv]
// a sample taken is written into the queue, and its first byte is then registered in the output register
// throughput: one byte per cycle while the receiver is ready; a sample costs 1, 2, 4 or 10 bytes,
// about 1.25 bytes per sample over a long packet, set by the single byte output port
// the sample queue (QUEUE_DEPTH entries) absorbs header and crc bursts
// reset: empty queue, sequence 0, crc 0xFFFF, op_mode 0, groups_per_packet 256
module adc_sample_packet_framer_top #(
    parameter int unsigned QUEUE_DEPTH = aspf_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    aspf_sample_if.sink                         sample_ch,
    aspf_byte_if.source                         byte_ch,
    input  logic                                cfg_we,
    input  logic [aspf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aspf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic               push;
    aspf_pkg::entry_t   push_entry;
    logic               queue_full;
    logic               pop;
    logic               head_valid;
    aspf_pkg::entry_t   head;

    // sample classification and packet counters
    aspf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    aspf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // byte sequencer with crc
    aspf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .byte_ch    (byte_ch)
    );

endmodule

[tb/tb_adc_sample_packet_framer_top.sv]
`timescale 1ns / 1ps

module tb_adc_sample_packet_framer_top;
    import aspf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SAMPLE_TARGET = 470;

    // one byte of the framed stream as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } framed_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    aspf_sample_if sample_ch ();
    aspf_byte_if   byte_ch ();

    adc_sample_packet_framer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .byte_ch   (byte_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies as seen by the framer
    logic                mode_reg;
    logic [GROUPS_W-1:0] groups_reg;

    // framer state
    logic [SEQ_W-1:0]    pkt_seq;
    logic [1:0]          phase_in_group;
    logic [GROUPS_W-1:0] group_count;
    logic [5:0]          low_pairs;
    logic [CRC_W-1:0]    running_crc;

    logic [SAMPLE_W-1:0] samples_to_send[$];
    framed_byte_t        framed_bytes_due[$];
    int unsigned         samples_queued;
    int unsigned         samples_taken;
    int unsigned         fail_count;
    int unsigned         cycle_count;
    logic                sample_fire;

    // sender burst and receiver stall bookkeeping
    int unsigned         burst_left;
    int unsigned         gap_left;
    logic [15:0]         stall_bits;
    int unsigned         stall_pos;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // crc-16 ccitt, one input bit at a time, msb first
    function automatic logic [CRC_W-1:0] crc_after_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ b[i];
            c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
        framed_byte_t fb;
        fb.value = value;
        fb.last = last;
        framed_bytes_due.push_back(fb);
    endtask

    task automatic push_payload(input logic [BYTE_W-1:0] value);
        running_crc = crc_after_byte(running_crc, value);
        push_byte(value, 1'b0);
    endtask

    // bytes one accepted sample should produce
    task automatic frame_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned     eff_groups;
        logic [LEN_W-1:0] len_field;
        eff_groups = (groups_reg == '0) ? 1 : int'(groups_reg);
        case (phase_in_group)
            2'd0:
            begin
                if (group_count == '0)
                begin
                    len_field = LEN_W'(eff_groups * 5);
                    push_byte(SYNC0, 1'b0);
                    push_byte(SYNC1, 1'b0);
                    push_byte(pkt_seq[7:0], 1'b0);
                    push_byte(pkt_seq[15:8], 1'b0);
                    push_byte(pkt_seq[23:16], 1'b0);
                    push_byte(pkt_seq[31:24], 1'b0);
                    push_byte({7'b0, mode_reg}, 1'b0);
                    push_byte(len_field[7:0], 1'b0);
                    push_byte(len_field[15:8], 1'b0);
                    running_crc = CRC_INIT;
                end
                push_payload(s[9:2]);
                low_pairs = {4'b0, s[1:0]};
                phase_in_group = 2'd1;
            end
            2'd3:
            begin
                push_payload(s[9:2]);
                push_payload({low_pairs, s[1:0]});
                low_pairs = '0;
                phase_in_group = 2'd0;
                if (int'(group_count) + 1 >= eff_groups)
                begin
                    push_byte(running_crc[7:0], 1'b0);
                    push_byte(running_crc[15:8], 1'b1);
                    running_crc = CRC_INIT;
                    group_count = '0;
                    pkt_seq = pkt_seq + 1'b1;
                end
                else
                    group_count = group_count + 1'b1;
            end
            default:
            begin
                push_payload(s[9:2]);
                low_pairs = {low_pairs[3:0], s[1:0]};
                phase_in_group = phase_in_group + 2'd1;
            end
        endcase
    endtask

    task automatic note_failure(input string what, input int unsigned want, input int unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s expected %0h actual %0h", $realtime, what, want, got);
    endtask

    // sample driver: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!sample_ch.valid || sample_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                sample_ch.valid <= 1'b0;
            end
            else if (samples_to_send.size() != 0)
            begin
                sample_ch.valid <= 1'b1;
                sample_ch.sample <= samples_to_send.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // byte receiver: ready steps through a 16-bit stall pattern, redrawn whenever it wraps around
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.ready <= 1'b0;
            stall_pos = 0;
        end
        else
        begin
            if (stall_pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_bits = 16'hFFFF;
                    1: stall_bits = 16'($urandom & $urandom) | 16'h0001;
                    default: stall_bits = 16'($urandom) | 16'h0001;
                endcase
            end
            byte_ch.ready <= stall_bits[stall_pos];
            stall_pos = (stall_pos + 1) % 16;
        end
    end

    // monitor: check bytes leaving the block, predict from samples taken
    always @(posedge clk)
    begin
        sample_fire <= rst_n && sample_ch.valid && sample_ch.ready;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (framed_bytes_due.size() == 0)
                note_failure("unexpected byte", 0, byte_ch.data_byte);
            else
            begin
                framed_byte_t want;
                want = framed_bytes_due.pop_front();
                if (byte_ch.data_byte !== want.value)
                    note_failure("data_byte", want.value, byte_ch.data_byte);
                if (byte_ch.packet_end !== want.last)
                    note_failure("packet_end", want.last, byte_ch.packet_end);
            end
        end
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            frame_sample(sample_ch.sample);
            samples_taken++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        samples_to_send.push_back(s);
        samples_queued++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OP_MODE)
            mode_reg = val[0];
        else
            groups_reg = val[GROUPS_W-1:0];
    endtask

    // let every queued sample through and every byte out
    task automatic wait_drained();
        while (samples_taken != samples_queued || framed_bytes_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        int unsigned n_items;
        int unsigned pick;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OP_MODE;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        byte_ch.ready = 1'b0;
        sample_fire = 1'b0;
        samples_queued = 0;
        samples_taken = 0;
        fail_count = 0;
        cycle_count = 0;
        mode_reg = 1'b0;
        groups_reg = GROUPS_RESET;
        pkt_seq = '0;
        phase_in_group = '0;
        group_count = '0;
        low_pairs = '0;
        running_crc = CRC_INIT;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: long packet header, sample extremes and alternating bits
        queue_sample(10'h000);
        queue_sample(10'h3FF);
        queue_sample(10'h155);
        queue_sample(10'h2AA);
        wait_drained();

        // zero group count acts as one, closing the packet mid-way
        write_reg(CFG_GROUPS, 14'd0);
        write_reg(CFG_OP_MODE, 14'd1);
        repeat (4) queue_sample(10'h3FF);
        wait_drained();

        // oversized group count, then shrunk mid-packet
        write_reg(CFG_GROUPS, 14'h3FFF);
        queue_sample(10'h001);
        queue_sample(10'h002);
        queue_sample(10'h200);
        queue_sample(10'h100);
        wait_drained();
        write_reg(CFG_GROUPS, 14'd2);
        write_reg(CFG_OP_MODE, 14'd0);
        queue_sample(10'h0FF);
        queue_sample(10'h300);
        queue_sample(10'h003);
        queue_sample(10'h3FC);
        wait_drained();

        // largest legal group count, cut short by a drop to one
        write_reg(CFG_GROUPS, 14'd13107);
        repeat (4) queue_sample(10'($urandom_range(0, 1023)));
        wait_drained();
        write_reg(CFG_GROUPS, 14'd1);
        repeat (4) queue_sample(10'($urandom_range(0, 1023)));
        wait_drained();

        // random phases, mostly short packets
        while (samples_queued < SAMPLE_TARGET)
        begin
            pick = $urandom_range(0, 19);
            write_reg(CFG_OP_MODE, 14'($urandom_range(0, 1)));
            case (pick)
                0: write_reg(CFG_GROUPS, 14'd0);
                1: write_reg(CFG_GROUPS, 14'd13107);
                2: write_reg(CFG_GROUPS, 14'h3FFF);
                3: write_reg(CFG_GROUPS, 14'($urandom_range(7, 40)));
                default: write_reg(CFG_GROUPS, 14'($urandom_range(1, 6)));
            endcase
            n_items = 4 * $urandom_range(2, 15);
            if ($urandom_range(0, 3) == 0)
                n_items += $urandom_range(1, 3);
            repeat (n_items)
            begin
                if ($urandom_range(0, 15) == 0)
                    queue_sample(($urandom_range(0, 1) == 0) ? 10'h000 : 10'h3FF);
                else
                    queue_sample(10'($urandom_range(0, 1023)));
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0 && framed_bytes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
design/aspf_pkg.sv
design/aspf_sample_if.sv
design/aspf_byte_if.sv
design/aspf_front.sv
design/aspf_queue.sv
design/aspf_back.sv
design/adc_sample_packet_framer_top.sv
tb/tb_adc_sample_packet_framer_top.sv
